[sv/kss_pkg.sv]
// Package for the keypad scanner and multiplexed seven-segment display.
// Holds the key codes, the segment table and the types shared by the modules.
// No dependencies.
package kss_pkg;

	localparam int DIGIT_COUNT_DEFAULT = 4;

	localparam logic [4:0] NO_KEY_CODE    = 5'd17;
	localparam logic [4:0] LAST_KEY_RESET = 5'd15;
	localparam logic [3:0] BLANK_DIGIT    = 4'hF;
	localparam logic [3:0] ENABLE_NONE    = 4'hF;

	typedef logic [4:0] key_code_t;
	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic [3:0] digit_enable;
		logic [7:0] segments;
	} disp_out_t;

	function automatic logic [7:0] seg_pattern(input digit_t d);
		logic [7:0] p;
		unique case (d)
			4'd0:    p = 8'h03;
			4'd1:    p = 8'h9F;
			4'd2:    p = 8'h25;
			4'd3:    p = 8'h0D;
			4'd4:    p = 8'h99;
			4'd5:    p = 8'h49;
			4'd6:    p = 8'h41;
			4'd7:    p = 8'h1F;
			4'd8:    p = 8'h01;
			4'd9:    p = 8'h09;
			4'd10:   p = 8'h41;
			4'd11:   p = 8'h1F;
			4'd12:   p = 8'h03;
			4'd13:   p = 8'h9F;
			4'd14:   p = 8'h25;
			default: p = 8'hFF;
		endcase
		return p;
	endfunction

endpackage

[sv/kss_key_encoder.sv]
// Keypad priority encoder: lowest-numbered pressed key, or the no-key code.
// Depends on kss_pkg.
module kss_key_encoder (
	input  logic [15:0]        key_matrix,
	output kss_pkg::key_code_t key_code
);
	import kss_pkg::*;

	always_comb begin
		key_code = NO_KEY_CODE;
		for (int i = 15; i >= 0; i--) begin
			if (key_matrix[i]) begin
				key_code = 5'(i);
			end
		end
	end

endmodule

[sv/kss_display.sv]
// Display state: digit phase, shown digits and last scanned key code.
// Produces the enable and segment pattern of the current digit per step.
// Depends on kss_pkg.
module kss_display #(
	parameter int DIGIT_COUNT = kss_pkg::DIGIT_COUNT_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  kss_pkg::key_code_t key_code,
	output kss_pkg::disp_out_t disp
);
	import kss_pkg::*;

	localparam int PHASE_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(DIGIT_COUNT - 1);

	logic [PHASE_W-1:0] phase_q;
	digit_t             digits_q [DIGIT_COUNT];
	key_code_t          last_key_q;

	logic       wrap;
	logic       enter;
	logic [3:0] phase_ext;

	assign wrap      = (phase_q == LAST_PHASE);
	assign enter     = step && wrap && (key_code != last_key_q) && (key_code != NO_KEY_CODE);
	assign phase_ext = 4'(phase_q);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			disp.digit_enable[i] = (phase_ext != 4'(i));
		end
		disp.segments = seg_pattern(digits_q[phase_q]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			last_key_q <= LAST_KEY_RESET;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digits_q[i] <= BLANK_DIGIT;
			end
		end else if (step) begin
			phase_q <= wrap ? '0 : phase_q + 1'b1;
			if (wrap && (key_code != last_key_q)) begin
				last_key_q <= key_code;
			end
			if (enter) begin
				for (int i = DIGIT_COUNT - 1; i > 0; i--) begin
					digits_q[i] <= digits_q[i-1];
				end
				digits_q[0] <= key_code[3:0];
			end
		end
	end

`ifndef SYNTH
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= LAST_PHASE)
		else $error("digit phase out of range");

	a_key_entered: assert property (@(posedge clk) disable iff (!arst_n)
		enter |=> digits_q[0] == $past(key_code[3:0]))
		else $error("new key not shifted into digit 0");

	a_last_code: assert property (@(posedge clk) disable iff (!arst_n)
		last_key_q == NO_KEY_CODE || last_key_q <= 5'd15)
		else $error("bad last key code");

	a_hold_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q))
		else $error("phase moved without a step");
`endif

endmodule

[sv/keypad_scan_seven_segment_display.sv]
// Keypad scanner with multiplexed seven-segment display, top level.
// Input register, key encoder, display state and result register.
// Depends on kss_pkg, kss_key_encoder and kss_display.
//
// Each input transaction is one timer tick carrying the sampled 4x4 keypad.
// The block takes one tick every clock cycle while out_ready holds high and
// returns one result per tick through the input register, then the result
// register; the digit state advances as a tick moves into the result register,
// so ticks can stream back to back while out_ready holds high. Each result
// shows the current digit; every DIGIT_COUNT-th tick also scans the keypad
// and shifts a newly pressed key into digit 0.
module keypad_scan_seven_segment_display #(
	parameter int DIGIT_COUNT = kss_pkg::DIGIT_COUNT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] key_matrix,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  digit_enable,
	output logic [7:0]  segments
);
	import kss_pkg::*;

	logic        valid_s1;
	logic [15:0] key_s1;
	logic        valid_s2;
	disp_out_t   result_s2;

	logic      load_s2;
	key_code_t key_code;
	disp_out_t disp;

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;

	kss_key_encoder u_encoder (
		.key_matrix (key_s1),
		.key_code   (key_code)
	);

	kss_display #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_display (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (load_s2),
		.key_code (key_code),
		.disp     (disp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1 <= key_matrix;
		end
		if (load_s2) begin
			result_s2 <= disp;
		end
	end

	assign out_valid    = valid_s2;
	assign digit_enable = result_s2.digit_enable;
	assign segments     = result_s2.segments;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> valid_s2 && $stable(result_s2))
		else $error("stalled result changed");

	a_one_enable: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $countones(~result_s2.digit_enable) <= 1)
		else $error("more than one digit enabled");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load_s2) |=> valid_s1 && $stable(key_s1))
		else $error("pending tick lost");
`endif

endmodule
